// ===== sv/smc_pkg.sv =====
package smc_pkg;

  typedef enum logic [1:0] {
    KIND_HOME = 2'd0,
    KIND_MOVE = 2'd1,
    KIND_TICK = 2'd2,
    KIND_END  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_HOMING = 2'd1,
    MODE_MOVING = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_STEP      = 2'd1,
    EV_MOVE_DONE = 2'd2,
    EV_HOME_DONE = 2'd3
  } event_t;

  localparam logic [1:0] CFG_TICK_SCALE      = 2'd0;
  localparam logic [1:0] CFG_REPORT_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_REPORT_STEP     = 2'd2;

  localparam logic [15:0] TICK_SCALE_RST      = 16'd3431;
  localparam logic [7:0]  REPORT_INTERVAL_RST = 8'd40;
  localparam logic [6:0]  REPORT_STEP_RST     = 7'd3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  step;
    logic        pulse_en;
    logic        dir;
    logic        last;
  } result_t;

  // results of one input word, headed for the output queue
  typedef struct packed {
    logic [1:0] push_cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ===== sv/smc_out_queue.sv =====
module smc_out_queue
  import smc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  output logic       has_room,
  output logic       m_tvalid,
  input  logic       m_tready,
  output result_t    head
);

  result_t              entries [QDEPTH];
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QCNT_W-1:0]    count;
  logic                 pop;
  logic [QPTR_W-1:0]    wr_ptr1;

  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  assign head     = entries[rd_ptr];
  // room for the worst case of two results
  assign has_room = (count <= QCNT_W'(QDEPTH - 2));
  assign wr_ptr1  = wr_ptr + QPTR_W'(1);

  always_ff @(posedge clk) begin
    if (push.push_cnt != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.push_cnt == 2'd2) begin
      entries[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.push_cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push.push_cnt) - QCNT_W'(pop);
    end
  end

endmodule

// ===== sv/stepper_move_controller.sv =====
// Channel   Dir  tdata (low bit up)                     tuser      tlast
// s_*       in   distance, retract                      kind       -
// m_*       out  position_step, pulse_enable, dir_out   event_res  last
// cfg_*     in   write enable, register index, data     -          -
//
// Each input word is decoded against the axis state in the cycle it is
// taken and gives one or two results, which go into a 4-entry output queue.
// A word is taken every cycle while the queue has room for two results, so
// single-result words stream at one per cycle; a word with two results
// gives two output words. Stalls on m_tready back up into s_tready through
// the queue. Reset (rst, synchronous) idles the axis and loads the register
// defaults.
module stepper_move_controller
  import smc_pkg::*;
#(
  parameter int DISTANCE_BITS = 16,
  parameter int TICK_BITS     = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((DISTANCE_BITS+8)/8)*8-1:0]   s_tdata,  // distance, retract
  input  logic [1:0]                           s_tuser,  // kind
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [15:0]                          m_tdata,  // position_step, pulse_enable,
                                                         // direction_out
  output logic [1:0]                           m_tuser,  // event_res
  output logic                                 m_tlast,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [15:0]                          cfg_data
);

  localparam int PROD_W = DISTANCE_BITS + 16;
  localparam int SHR_W  = DISTANCE_BITS + 8;
  localparam int CMP_W  = (SHR_W > TICK_BITS) ? SHR_W : TICK_BITS;

  logic [15:0]          tick_scale;
  logic [7:0]           report_interval;
  logic [6:0]           report_step;

  mode_t                mode, mode_next;
  logic [TICK_BITS-1:0] ticks_left, ticks_next;
  logic signed [8:0]    pos_count, pos_count_next;
  logic                 moving_back, moving_back_next;

  kind_t                kind;
  logic [DISTANCE_BITS-1:0] distance;
  logic                 retract;
  logic                 s_accept;

  logic [PROD_W-1:0]    prod;
  logic [CMP_W-1:0]     t_ext;
  logic [CMP_W-1:0]     t_max;
  logic [TICK_BITS-1:0] move_ticks;

  logic [TICK_BITS-1:0] tick_dec;
  logic signed [8:0]    count_step;
  logic [8:0]           count_mag;
  logic                 report;
  logic [7:0]           step_val;
  logic                 done;

  event_t               ev0, ev1;
  logic [7:0]           step0;
  logic                 two;
  push_t                push;
  logic                 has_room;
  result_t              head;

  assign kind     = kind_t'(s_tuser);
  assign distance = s_tdata[DISTANCE_BITS-1:0];
  assign retract  = s_tdata[DISTANCE_BITS];
  assign s_tready = has_room;
  assign s_accept = s_tvalid && has_room;

  // distance * Q8.8 scale, saturated to the tick counter
  assign prod       = PROD_W'(distance) * PROD_W'(tick_scale);
  assign t_ext      = CMP_W'(prod[PROD_W-1:8]);
  assign t_max      = CMP_W'({TICK_BITS{1'b1}});
  assign move_ticks = (t_ext > t_max) ? t_max[TICK_BITS-1:0] : t_ext[TICK_BITS-1:0];

  assign tick_dec   = (mode == MODE_MOVING && ticks_left != '0)
                      ? ticks_left - TICK_BITS'(1) : ticks_left;
  assign count_step = moving_back ? pos_count - 9'sd1 : pos_count + 9'sd1;
  assign count_mag  = count_step[8] ? 9'(-count_step) : 9'(count_step);
  assign report     = (count_step != 9'sd0) && (count_mag >= {1'b0, report_interval});
  assign step_val   = count_step[8] ? 8'(-{1'b0, report_step}) : {1'b0, report_step};
  assign done       = (mode == MODE_MOVING) && (tick_dec == '0);

  always_comb begin
    mode_next        = mode;
    ticks_next       = ticks_left;
    pos_count_next   = pos_count;
    moving_back_next = moving_back;
    ev0              = EV_NONE;
    ev1              = EV_NONE;
    step0            = '0;
    two              = 1'b0;
    case (kind)
      KIND_HOME: begin
        if (mode == MODE_IDLE) begin
          mode_next        = MODE_HOMING;
          moving_back_next = 1'b1;
        end
      end
      KIND_MOVE: begin
        if (mode == MODE_IDLE) begin
          moving_back_next = retract;
          ticks_next       = move_ticks;
          if (move_ticks == '0) begin
            ev0 = EV_MOVE_DONE;
          end else begin
            mode_next = MODE_MOVING;
          end
        end
      end
      KIND_TICK: begin
        if (mode != MODE_IDLE) begin
          ticks_next     = tick_dec;
          pos_count_next = count_step;
          if (report) begin
            ev0            = EV_STEP;
            step0          = step_val;
            pos_count_next = '0;
          end
          if (done) begin
            mode_next = MODE_IDLE;
            if (report) begin
              ev1 = EV_MOVE_DONE;
              two = 1'b1;
            end else begin
              ev0 = EV_MOVE_DONE;
            end
          end
        end
      end
      KIND_END: begin
        if (mode == MODE_MOVING) begin
          mode_next  = MODE_IDLE;
          ticks_next = '0;
          ev0        = EV_MOVE_DONE;
        end else if (mode == MODE_HOMING) begin
          mode_next      = MODE_IDLE;
          pos_count_next = '0;
          ev0            = EV_HOME_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // pin levels in every result are those left by the word
  always_comb begin
    push.push_cnt    = s_accept ? (two ? 2'd2 : 2'd1) : 2'd0;
    push.r0.ev       = ev0;
    push.r0.step     = step0;
    push.r0.pulse_en = (mode_next != MODE_IDLE);
    push.r0.dir      = moving_back_next;
    push.r0.last     = !two;
    push.r1.ev       = ev1;
    push.r1.step     = '0;
    push.r1.pulse_en = (mode_next != MODE_IDLE);
    push.r1.dir      = moving_back_next;
    push.r1.last     = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_scale      <= TICK_SCALE_RST;
      report_interval <= REPORT_INTERVAL_RST;
      report_step     <= REPORT_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_SCALE:      tick_scale      <= cfg_data;
        CFG_REPORT_INTERVAL: report_interval <= cfg_data[7:0];
        CFG_REPORT_STEP:     report_step     <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      ticks_left  <= '0;
      pos_count   <= '0;
      moving_back <= 1'b0;
    end else if (s_accept) begin
      mode        <= mode_next;
      ticks_left  <= ticks_next;
      pos_count   <= pos_count_next;
      moving_back <= moving_back_next;
    end
  end

  smc_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .has_room (has_room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = {6'b0, head.dir, head.pulse_en, head.step};
  assign m_tuser = head.ev;
  assign m_tlast = head.last;

endmodule

// ===== tb/sv/tb_stepper_move_controller.sv =====
module tb_stepper_move_controller;
  import smc_pkg::*;

  localparam int IDLE_LIMIT = 200;
  localparam int WORDS_PER_PHASE = 130;

  // Tracks the axis the way the block should and holds the results still owed.
  class stepper_scoreboard;
    logic [15:0] tick_scale;
    logic [7:0]  report_interval;
    logic [6:0]  report_step;
    mode_t       mode;
    logic [23:0] ticks_left;
    int          position_count;
    logic        moving_back;
    result_t     owed_q[$];
    int          mismatches;

    function new();
      tick_scale      = TICK_SCALE_RST;
      report_interval = REPORT_INTERVAL_RST;
      report_step     = REPORT_STEP_RST;
      mode            = MODE_IDLE;
      ticks_left      = '0;
      position_count  = 0;
      moving_back     = 1'b0;
      mismatches      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_TICK_SCALE:      tick_scale = data;
        CFG_REPORT_INTERVAL: report_interval = data[7:0];
        CFG_REPORT_STEP:     report_step = data[6:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // Advance the axis by one accepted word and queue the results it owes.
    function void note_input(kind_t kind, logic [15:0] units, logic retract);
      event_t      ev[2];
      logic [7:0]  stp[2];
      int          n;
      int          mag;
      logic [31:0] prod;
      result_t     r;
      n = 0;
      stp[0] = 8'd0;
      stp[1] = 8'd0;
      case (kind)
        KIND_HOME: begin
          if (mode == MODE_IDLE) begin
            mode = MODE_HOMING;
            moving_back = 1'b1;
          end
          ev[n] = EV_NONE; n++;
        end
        KIND_MOVE: begin
          if (mode == MODE_IDLE) begin
            // Q8.8 product shifted down always fits in 24 bits
            prod = 32'(units) * 32'(tick_scale);
            moving_back = retract;
            ticks_left = prod[31:8];
            if (ticks_left == 0) begin
              ev[n] = EV_MOVE_DONE; n++;
            end else begin
              mode = MODE_MOVING;
              ev[n] = EV_NONE; n++;
            end
          end else begin
            ev[n] = EV_NONE; n++;
          end
        end
        KIND_TICK: begin
          if (mode != MODE_IDLE) begin
            if (mode == MODE_MOVING && ticks_left != 0) ticks_left--;
            position_count += moving_back ? -1 : 1;
            mag = position_count < 0 ? -position_count : position_count;
            if (position_count != 0 && mag >= int'(report_interval)) begin
              ev[n] = EV_STEP;
              stp[n] = position_count > 0 ? {1'b0, report_step} : 8'(-int'(report_step));
              n++;
              position_count = 0;
            end
            if (mode == MODE_MOVING && ticks_left == 0) begin
              mode = MODE_IDLE;
              ev[n] = EV_MOVE_DONE; n++;
            end
          end
          if (n == 0) begin
            ev[n] = EV_NONE; n++;
          end
        end
        default: begin
          if (mode == MODE_MOVING) begin
            mode = MODE_IDLE;
            ticks_left = '0;
            ev[n] = EV_MOVE_DONE; n++;
          end else if (mode == MODE_HOMING) begin
            mode = MODE_IDLE;
            position_count = 0;
            ev[n] = EV_HOME_DONE; n++;
          end else begin
            ev[n] = EV_NONE; n++;
          end
        end
      endcase
      for (int k = 0; k < n; k++) begin
        r.ev       = ev[k];
        r.step     = stp[k];
        r.pulse_en = (mode != MODE_IDLE);
        r.dir      = moving_back;
        r.last     = (k == n - 1);
        owed_q.push_back(r);
      end
    endfunction

    task check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result with nothing owed, event %0d", got.ev));
        return;
      end
      want = owed_q.pop_front();
      if (got.ev !== want.ev)
        report($sformatf("event_res %0d, wanted %0d", got.ev, want.ev));
      if (got.step !== want.step)
        report($sformatf("position_step %0h, wanted %0h", got.step, want.step));
      if (got.pulse_en !== want.pulse_en)
        report($sformatf("pulse_enable %0b, wanted %0b", got.pulse_en, want.pulse_en));
      if (got.dir !== want.dir)
        report($sformatf("direction_out %0b, wanted %0b", got.dir, want.dir));
      if (got.last !== want.last)
        report($sformatf("last %0b, wanted %0b", got.last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // distance, retract
  logic [1:0]  s_tuser;   // kind
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // position_step, pulse_enable, direction_out
  logic [1:0]  m_tuser;   // event_res
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  stepper_scoreboard sb;
  result_t           out_word;
  bit                s_steady;
  bit                m_steady;
  int                words_sent;
  int                idle_cycles;

  always #5 clk = ~clk;

  stepper_move_controller uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  task automatic send_word(kind_t kind, logic [15:0] units, logic retract);
    int gap;
    gap = s_steady ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'd0, retract, units};
    do @(posedge clk); while (!s_tready);
    sb.note_input(kind, units, retract);
    words_sent++;
    if ($urandom_range(0, 39) == 0) s_steady = ~s_steady;
  endtask

  task automatic send_tick();
    send_word(KIND_TICK, 16'($urandom), 1'($urandom));
  endtask

  task automatic send_noise();
    send_word(kind_t'(2'($urandom)), 16'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  // stop sending and let every owed result come out
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(int scale, int interval, int step);
    drain();
    write_reg(CFG_TICK_SCALE, 16'(scale));
    write_reg(CFG_REPORT_INTERVAL, 16'(interval));
    write_reg(CFG_REPORT_STEP, 16'(step));
  endtask

  // one move, ticked to completion or cut short by the end switch
  task automatic run_move();
    int target;
    int units;
    int scale;
    int budget;
    scale = int'(sb.tick_scale);
    if ($urandom_range(0, 9) == 0 || scale == 0) begin
      units = $urandom_range(0, 65535);
    end else begin
      target = $urandom_range(0, 120);
      units = (target * 256 + scale - 1) / scale;
      if (units > 65535) units = 65535;
    end
    send_word(KIND_MOVE, 16'(units), 1'($urandom));
    if (sb.ticks_left <= 300 && $urandom_range(0, 4) != 0)
      budget = int'(sb.ticks_left) + $urandom_range(0, 2);
    else
      budget = $urandom_range(0, 40);
    repeat (budget) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_tick();
    end
    if (sb.mode != MODE_IDLE) send_word(KIND_END, 16'($urandom), 1'($urandom));
  endtask

  task automatic run_homing();
    int budget;
    send_word(KIND_HOME, 16'($urandom), 1'($urandom));
    budget = 2 * int'(sb.report_interval) + 10;
    if (budget > 300) budget = 300;
    repeat ($urandom_range(0, budget)) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_tick();
    end
    send_word(KIND_END, 16'($urandom), 1'($urandom));
    if ($urandom_range(0, 5) == 0) send_word(KIND_END, 16'($urandom), 1'($urandom));
  endtask

  // receiver: drop m_tready at random before a result word, except while m_steady is set
  initial begin
    int gap;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      gap = m_steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      out_word.ev       = event_t'(m_tuser);
      out_word.step     = m_tdata[7:0];
      out_word.pulse_en = m_tdata[8];
      out_word.dir      = m_tdata[9];
      out_word.last     = m_tlast;
      sb.check_result(out_word);
      if ($urandom_range(0, 39) == 0) m_steady = ~m_steady;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int goal;
    int pick;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_steady = 1'b0;
    m_steady = 1'b0;
    words_sent = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one tick per unit and a tiny interval make every case show up quickly
    configure(256, 2, 127);
    send_tick();                              // idle tick
    send_word(KIND_END, 16'hFFFF, 1'b1);      // end switch while idle
    send_word(KIND_MOVE, 16'd0, 1'b1);        // zero-tick move
    send_word(KIND_MOVE, 16'd4, 1'b0);
    send_word(KIND_MOVE, 16'hFFFF, 1'b1);     // busy, ignored
    send_word(KIND_HOME, 16'h0000, 1'b0);     // busy, ignored
    repeat (4) send_tick();                   // last one: step then done
    send_tick();                              // no second done
    send_word(KIND_END, 16'd0, 1'b0);
    send_word(KIND_MOVE, 16'd1, 1'b0);
    send_tick();
    send_word(KIND_MOVE, 16'd1, 1'b1);
    send_tick();                              // counter back to zero, no report
    send_word(KIND_HOME, 16'd0, 1'b0);
    repeat (3) send_tick();
    send_word(KIND_END, 16'd0, 1'b0);         // homing done, counter cleared
    send_word(KIND_END, 16'd0, 1'b0);
    send_word(KIND_MOVE, 16'hFFFF, 1'b1);
    send_tick();
    send_word(KIND_END, 16'd0, 1'b0);         // abort

    // the last move or homing of a phase may run past the goal
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: configure(TICK_SCALE_RST, REPORT_INTERVAL_RST, REPORT_STEP_RST);
        1: configure(0, 1, 0);
        2: configure(65535, 255, 127);
        3: configure(256, 1, 127);
        4: configure($urandom_range(1, 65535), $urandom_range(1, 255), $urandom_range(0, 127));
        default: configure(600, 7, 64);
      endcase
      goal = words_sent + WORDS_PER_PHASE;
      while (words_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) run_move();
        else if (pick < 65) run_homing();
        else send_noise();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never came", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
